FILE: sv/signed_divide_truncating_assert.svh
// Assertion macros for the signed divider RTL.
// Depends on nothing; the including module provides clk and rst.
`ifndef SIGNED_DIVIDE_TRUNCATING_ASSERT_SVH
`define SIGNED_DIVIDE_TRUNCATING_ASSERT_SVH

// Checked only outside reset.
`define SDT_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sdt_pkg.sv
// Package for the signed truncating divider: widths, status codes and the
// transaction and pipeline stage structs. Depends on nothing.
package sdt_pkg;

  localparam int DATA_W  = 32;
  // Front stage, one cell per quotient bit, back stage.
  localparam int LATENCY = DATA_W + 2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] numerator;
    logic signed [DATA_W-1:0] denominator;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient;
    logic signed [DATA_W-1:0] remainder;
    status_t                  status;
  } result_t;

  // Work in flight between two cells of the chain.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] rem;     // partial remainder magnitude
    logic [DATA_W-1:0] quo;     // dividend bits still to shift out, quotient bits in
    logic [DATA_W-1:0] dvs;     // divisor magnitude
    logic              neg_q;
    logic              neg_r;
    status_t           status;
  } stage_t;

endpackage

FILE: sv/sdt_front.sv
// Entry stage of the divider: operand magnitudes, signs and special cases.
// Depends on sdt_pkg.
module sdt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sdt_pkg::request_t request,
  output sdt_pkg::stage_t   dout
);
  import sdt_pkg::*;

  logic              valid;
  logic [DATA_W-1:0] mag_n;
  logic [DATA_W-1:0] mag_d;
  logic              neg_q;
  logic              neg_r;
  status_t           status;

  logic              num_neg;
  logic              den_neg;
  logic              div_zero;
  logic              overflow;
  logic [DATA_W-1:0] n_bits;
  logic [DATA_W-1:0] d_bits;

  always_comb begin
    n_bits   = request.numerator;
    d_bits   = request.denominator;
    num_neg  = n_bits[DATA_W-1];
    den_neg  = d_bits[DATA_W-1];
    div_zero = (d_bits == '0);
    overflow = (n_bits == {1'b1, {(DATA_W-1){1'b0}}}) && (d_bits == '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= load;
    end
  end

  // A zero divisor makes every trial subtraction succeed, so the quotient
  // comes out as all ones and the remainder as the numerator magnitude; the
  // quotient is then left unsigned. The overflow case needs no correction.
  always_ff @(posedge clk) begin
    mag_n <= num_neg ? (~n_bits + 1'b1) : n_bits;
    mag_d <= den_neg ? (~d_bits + 1'b1) : d_bits;
    neg_q <= (num_neg ^ den_neg) && !div_zero;
    neg_r <= num_neg;
    if (div_zero) begin
      status <= STATUS_DIV_ZERO;
    end else if (overflow) begin
      status <= STATUS_OVERFLOW;
    end else begin
      status <= STATUS_OK;
    end
  end

  assign dout = '{valid: valid, rem: '0, quo: mag_n, dvs: mag_d,
                  neg_q: neg_q, neg_r: neg_r, status: status};

endmodule

FILE: sv/sdt_cell.sv
// One restoring division step, registered: develops one quotient bit.
// Depends on sdt_pkg.
module sdt_cell (
  input  logic            clk,
  input  logic            rst,
  input  sdt_pkg::stage_t din,
  output sdt_pkg::stage_t dout
);
  import sdt_pkg::*;

  logic              valid;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg_q;
  logic              neg_r;
  status_t           status;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;

  always_comb begin
    shifted = {din.rem, din.quo[DATA_W-1]};
    trial   = shifted - {1'b0, din.dvs};
    fits    = !trial[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
    quo    <= {din.quo[DATA_W-2:0], fits};
    dvs    <= din.dvs;
    neg_q  <= din.neg_q;
    neg_r  <= din.neg_r;
    status <= din.status;
  end

  assign dout = '{valid: valid, rem: rem, quo: quo, dvs: dvs,
                  neg_q: neg_q, neg_r: neg_r, status: status};

endmodule

FILE: sv/sdt_back.sv
// Exit stage of the divider: restores the signs and registers the result.
// Depends on sdt_pkg.
module sdt_back (
  input  logic             clk,
  input  logic             rst,
  input  sdt_pkg::stage_t  din,
  output logic             done,
  output sdt_pkg::result_t result
);
  import sdt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.quotient  <= din.neg_q ? (~din.quo + 1'b1) : din.quo;
    result.remainder <= din.neg_r ? (~din.rem + 1'b1) : din.rem;
    result.status    <= din.status;
  end

endmodule

FILE: sv/signed_divide_truncating.sv
// Signed divider truncating toward zero, built as a pipelined chain of cells.
// Between the accepting edge and the done strobe lie one entry stage, one
// cell for each of the 32 quotient bits and one exit stage.
// Throughput is one transaction per cycle outside reset; the receiver cannot stall the chain.
// Synchronous reset drops all work in flight and holds busy high while active.
// Depends on sdt_pkg, sdt_front, sdt_cell, sdt_back and the assertion header.
`include "signed_divide_truncating_assert.svh"

module signed_divide_truncating (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sdt_pkg::request_t request,
  output logic             done,
  output sdt_pkg::result_t result
);
  import sdt_pkg::*;

  // The chain never backs up, since every stage advances on every clock and
  // the receiver takes each result as it appears. The only time a transaction
  // is refused is during reset.
  assign busy = rst;

  // chain[0] is the entry stage output, chain[DATA_W] feeds the exit stage.
  stage_t chain [0:DATA_W];

  // A result flagged as a division by zero is on the outputs.
  logic zero_div_done;

  // The entry stage takes the operand magnitudes and records the signs that
  // the exit stage will put back. Both special cases are decided here and
  // ride along as a status code.
  sdt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .load    (start && !busy),
    .request (request),
    .dout    (chain[0])
  );

  // Each cell shifts one dividend bit into the partial remainder, tries a
  // subtraction of the divisor and keeps the difference if it does not go
  // negative. The quotient bits collect where the dividend bits left.
  for (genvar i = 0; i < DATA_W; i++) begin : g_cell
    sdt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // The exit stage negates the quotient when the operand signs differ and the divisor is not zero, and
  // gives the remainder the sign of the numerator.
  sdt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .din    (chain[DATA_W]),
    .done   (done),
    .result (result)
  );

  assign zero_div_done = done && (result.status == STATUS_DIV_ZERO);

  // Every accepted transaction comes out as a done strobe once it has passed the
  // whole chain, and every done strobe matches an earlier accept.
  `SDT_ASSERT_RUN(a_latency, (start && !busy) |-> ##LATENCY done, "result missing after accept")
  `SDT_ASSERT_RUN(a_no_phantom, done |-> $past(start && !busy, LATENCY), "result without accept")
  // A zero divisor must give an all ones quotient, whatever the signs were.
  `SDT_ASSERT_ALWAYS(a_div_zero_q, zero_div_done |-> &result.quotient, "bad zero divisor quotient")

endmodule
